@@ design/piece_progress_bitmap_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the piece progress bitmap tracker
// Shorthand for clocked checks that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PIECE_PROGRESS_BITMAP_TRACKER_MACROS_SVH
`define PIECE_PROGRESS_BITMAP_TRACKER_MACROS_SVH

// Same-cycle implication
`define PPBT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define PPBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/ppbt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppbt_pkg
// Shared constants, codes, controller states and helper functions.
// ----------------------------------------------------------------------------
package ppbt_pkg;

    // Defaults for the top-level parameters
    localparam int BODY_BLOCKS_DEF = 256;
    localparam int MAX_PICKS_DEF   = 32;

    // Fixed geometry
    localparam int BLOCK_BYTES     = 64;
    localparam int BLOCK_SHIFT     = 6;
    localparam int MANIFEST_BLOCKS = 16;
    localparam int MAN_BYTES       = (MANIFEST_BLOCKS + 7) / 8;
    localparam int MAN_BYTE_W      = (MAN_BYTES > 1) ? $clog2(MAN_BYTES) : 1;

    // Field widths
    localparam int OFFSET_W = 24;
    localparam int BUNDLE_W = 8;
    localparam int TRK_W    = 9;
    localparam int PIECE_W  = 12;
    localparam int RND_W    = 16;
    localparam int MSO_W    = 11;
    localparam int OP_W     = 2;

    // Stream widths
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [OFFSET_W-1:0] NEAR_START     = OFFSET_W'(16384);
    localparam logic [OFFSET_W-1:0] OFFSET_MAX     = {OFFSET_W{1'b1}};
    localparam logic [TRK_W-1:0]    NO_BUNDLE      = {TRK_W{1'b1}};
    localparam logic [MSO_W-1:0]    MAN_FULL_POINT = MSO_W'(MANIFEST_BLOCKS * BLOCK_BYTES);

    typedef enum logic [OP_W-1:0] {
        OP_OBSERVE = 2'd0,
        OP_MOVE    = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic {
        CFG_SENDING_BUNDLE = 1'b0,
        CFG_BODY_LENGTH    = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_COUNT,
        ST_BPICK,
        ST_BMOD,
        ST_BSEL,
        ST_MPICK,
        ST_MMOD,
        ST_MSEL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic count_step;
        logic body_pick;
        logic bsel_step;
        logic man_pick;
        logic msel_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic update_go;
        logic body_last;
        logic body_none;
        logic man_none;
        logic sel_found;
        logic mod_done;
        logic mod_busy;
    } dp_sts_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            c = c + 4'(v[k]);
        end
        return c;
    endfunction

    // Position of the j-th set bit, counting from bit 0
    function automatic logic [2:0] nth_set8(input logic [7:0] v, input logic [2:0] j);
        logic [3:0] seen;
        logic [2:0] pos;
        logic       hit;
        seen = '0;
        pos  = '0;
        hit  = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (v[k] && !hit) begin
                if (seen == {1'b0, j}) begin
                    pos = 3'(k);
                    hit = 1'b1;
                end
                seen = seen + 4'd1;
            end
        end
        return pos;
    endfunction

endpackage

@@ design/ppbt_mod_unit.sv @@
// ----------------------------------------------------------------------------
// ppbt_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ppbt_mod_unit #(
    parameter int DIV_W = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [ppbt_pkg::RND_W-1:0] dividend,
    input  logic [DIV_W-1:0]         divisor,
    output logic                     busy,
    output logic                     done,
    output logic [DIV_W-1:0]         remainder
);
    import ppbt_pkg::*;

    localparam int ITER_W = $clog2(RND_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [RND_W-1:0]  sh_reg, sh_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [DIV_W:0]    trial;

    // One restoring step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, sh_reg[RND_W-1]};
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            sh_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            sh_next   = {sh_reg[RND_W-2:0], 1'b0};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(RND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ design/ppbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppbt_ctrl
// Controller: sequences dispatch, bitmap scans, modulo and result handoff.
// ----------------------------------------------------------------------------
module ppbt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ppbt_pkg::dp_sts_t   sts,
    output ppbt_pkg::ctrl_cmd_t cmd
);
    import ppbt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
            ST_DISPATCH: state_next = sts.update_go ? ST_COUNT : ST_DONE;
            ST_COUNT:    if (sts.body_last) state_next = ST_BPICK;
            ST_BPICK:    state_next = sts.body_none ? ST_MPICK : ST_BMOD;
            ST_BMOD:     if (sts.mod_done) state_next = ST_BSEL;
            ST_BSEL:     if (sts.sel_found) state_next = ST_MPICK;
            ST_MPICK:    state_next = sts.man_none ? ST_DONE : ST_MMOD;
            ST_MMOD:     if (sts.mod_done) state_next = ST_MSEL;
            ST_MSEL:     if (sts.sel_found) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:     cmd.load       = s_tvalid;
            ST_DISPATCH: cmd.exec       = 1'b1;
            ST_COUNT:    cmd.count_step = 1'b1;
            ST_BPICK:    cmd.body_pick  = 1'b1;
            ST_BMOD:     cmd            = '0;
            ST_BSEL:     cmd.bsel_step  = 1'b1;
            ST_MPICK:    cmd.man_pick   = 1'b1;
            ST_MMOD:     cmd            = '0;
            ST_MSEL:     cmd.msel_step  = 1'b1;
            ST_DONE:     cmd.out_load   = out_free;
            default:     cmd            = '0;
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

@@ design/ppbt_datapath.sv @@
// ----------------------------------------------------------------------------
// ppbt_datapath
// Bitmaps, window base, send points, configuration and byte-wise scanner.
// ----------------------------------------------------------------------------
module ppbt_datapath #(
    parameter int BODY_BLOCKS = ppbt_pkg::BODY_BLOCKS_DEF,
    parameter int MAX_PICKS   = ppbt_pkg::MAX_PICKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ppbt_pkg::ctrl_cmd_t           cmd,
    output ppbt_pkg::dp_sts_t             sts,
    input  logic                          cfg_wr,
    input  logic                          cfg_index,
    input  logic [ppbt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [ppbt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [ppbt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic [ppbt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [ppbt_pkg::M_TUSER_W-1:0]  m_tuser
);
    import ppbt_pkg::*;

    localparam int NBYTES = (BODY_BLOCKS + 7) / 8;
    localparam int BYW    = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int LIM_W  = $clog2(NBYTES * 8 + 1);
    localparam int CNT_W  = $clog2(MAX_PICKS + 1);
    localparam int SUM_W  = CNT_W + 5;
    localparam int BIDX_W = OFFSET_W + 1 - BLOCK_SHIFT;
    localparam int MARK_W = BIDX_W + 1;

    // Configuration
    logic [TRK_W-1:0]    snd_reg, snd_next;
    logic [OFFSET_W-1:0] blen_reg, blen_next;

    // Tracker state
    logic [BODY_BLOCKS-1:0]     bm_reg, bm_next;
    logic [MANIFEST_BLOCKS-1:0] mbm_reg, mbm_next;
    logic [OFFSET_W-1:0]        wb_reg, wb_next;
    logic [TRK_W-1:0]           trk_reg, trk_next;
    logic [OFFSET_W-1:0]        bsp_reg, bsp_next;
    logic [MSO_W-1:0]           msp_reg, msp_next;

    // Latched request
    logic [OP_W-1:0]     op_reg;
    logic                man_reg;
    logic [BUNDLE_W-1:0] bid_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [PIECE_W-1:0]  bytes_reg;
    logic [OFFSET_W-1:0] pbl_reg;
    logic [OFFSET_W-1:0] nb_reg;
    logic [RND_W-1:0]    rnd_reg;
    logic                upd_reg, upd_next;

    // Scanner
    logic [BYW-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] n1_reg, n1_next;
    logic [CNT_W-1:0] n2_reg, n2_next;
    logic [LIM_W-1:0] lim_reg, lim_next;
    logic             pass2_reg, pass2_next;

    // Result register
    logic [OFFSET_W-1:0] out_bsp_reg;
    logic [MSO_W-1:0]    out_msp_reg;
    logic                out_upd_reg;

    // Modulo unit hookup
    logic             mod_start;
    logic [CNT_W-1:0] mod_div;
    logic             mod_busy, mod_done;
    logic [CNT_W-1:0] mod_rem;

    // Observe terms
    logic                   is_reset;
    logic [TRK_W-1:0]       trk_eff;
    logic [OFFSET_W-1:0]    wb_eff;
    logic [OFFSET_W:0]      piece_end;
    logic                   mark_ok, man_ok;
    logic [OFFSET_W-1:0]    rel;
    logic [BLOCK_SHIFT:0]   skip;
    logic [OFFSET_W:0]      rel2;
    logic [PIECE_W-1:0]     left;
    logic [BIDX_W-1:0]      b_first;
    logic [MARK_W-1:0]      b_end;
    logic [BODY_BLOCKS-1:0] mark_mask;
    logic [MANIFEST_BLOCKS-1:0] man_mask;

    // Move terms
    logic [OFFSET_W:0]      delta;
    logic [OFFSET_W:0]      delta_abs;
    logic [BIDX_W-1:0]      shamt;
    logic [BODY_BLOCKS-1:0] moved;

    // Update terms
    logic [OFFSET_W-1:0] span;
    logic [BIDX_W-1:0]   span_blocks;
    logic [LIM_W-1:0]    limit;
    logic [OFFSET_W:0]   win_end_sum;
    logic [OFFSET_W-1:0] win_end;

    // Byte scan terms
    logic [NBYTES*8-1:0] bm_pad;
    logic [7:0]          bm_byte;
    logic [7:0]          p1_byte, p2_byte;
    logic [MAN_BYTES*8-1:0] man_free;
    logic [7:0]          man_byte;
    logic [7:0]          sel_byte;
    logic [3:0]          sel_pop;
    logic [SUM_W-1:0]    acc_sum;
    logic [2:0]          sel_j;
    logic [2:0]          sel_pos;
    logic [LIM_W-1:0]    body_sel;
    logic [OFFSET_W:0]   body_sel_sum;
    logic [SUM_W-1:0]    n1_sum, n2_sum;
    logic [4:0]          man_cnt_raw;
    logic [CNT_W-1:0]    man_cnt;
    logic [LIM_W-1:0]    blk_i;

    ppbt_mod_unit #(
        .DIV_W(CNT_W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (rnd_reg),
        .divisor  (mod_div),
        .busy     (mod_busy),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    // Piece classification and block range for an observed piece
    always_comb begin
        is_reset  = (trk_reg == NO_BUNDLE) ||
                    (snd_reg != NO_BUNDLE && snd_reg == {1'b0, bid_reg} && trk_reg != snd_reg);
        trk_eff   = is_reset ? {1'b0, bid_reg} : trk_reg;
        wb_eff    = is_reset ? ((off_reg > NEAR_START) ? off_reg : '0) : wb_reg;
        piece_end = {1'b0, off_reg} + (OFFSET_W + 1)'(bytes_reg);
        man_ok    = is_reset || (trk_reg == {1'b0, bid_reg});
        mark_ok   = (trk_eff == {1'b0, bid_reg}) && (off_reg >= wb_eff);
        rel       = off_reg - wb_eff;
        skip      = '0;
        if (rel[BLOCK_SHIFT-1:0] != '0 && piece_end < {1'b0, pbl_reg}) begin
            skip = (BLOCK_SHIFT + 1)'(BLOCK_BYTES) - {1'b0, rel[BLOCK_SHIFT-1:0]};
        end
        rel2    = {1'b0, rel} + (OFFSET_W + 1)'(skip);
        left    = (bytes_reg > PIECE_W'(skip)) ? bytes_reg - PIECE_W'(skip) : '0;
        b_first = rel2[OFFSET_W:BLOCK_SHIFT];
        b_end   = {1'b0, b_first} + MARK_W'(left[PIECE_W-1:BLOCK_SHIFT]);
        for (int i = 0; i < BODY_BLOCKS; i++) begin
            mark_mask[i] = (MARK_W'(i) >= {1'b0, b_first}) && (MARK_W'(i) < b_end);
        end
        for (int j = 0; j < MANIFEST_BLOCKS; j++) begin
            man_mask[j] = (off_reg <= OFFSET_W'(j * BLOCK_BYTES)) &&
                          (piece_end >= (OFFSET_W + 1)'((j + 1) * BLOCK_BYTES));
        end
    end

    // Window move: shift by whole blocks, truncated toward zero
    always_comb begin
        delta     = {1'b0, nb_reg} - {1'b0, wb_reg};
        delta_abs = delta[OFFSET_W] ? (~delta + 1'b1) : delta;
        shamt     = delta_abs[OFFSET_W:BLOCK_SHIFT];
        moved     = delta[OFFSET_W] ? (bm_reg << shamt) : (bm_reg >> shamt);
        moved[0]  = 1'b0;
    end

    // Candidate range and window end for send-point update
    always_comb begin
        span        = blen_reg - wb_reg;
        span_blocks = BIDX_W'(span[OFFSET_W-1:BLOCK_SHIFT]) +
                      BIDX_W'(|span[BLOCK_SHIFT-1:0]);
        limit       = '0;
        if (blen_reg > wb_reg) begin
            limit = (span_blocks > BIDX_W'(BODY_BLOCKS)) ? LIM_W'(BODY_BLOCKS)
                                                         : LIM_W'(span_blocks);
        end
        win_end_sum = {1'b0, wb_reg} + (OFFSET_W + 1)'(BODY_BLOCKS * BLOCK_BYTES);
        win_end     = win_end_sum[OFFSET_W] ? OFFSET_MAX : win_end_sum[OFFSET_W-1:0];
    end

    // Candidate bytes at the current scan index
    always_comb begin
        bm_pad                  = '0;
        bm_pad[BODY_BLOCKS-1:0] = bm_reg;
        bm_byte                 = bm_pad[{idx_reg, 3'b000} +: 8];
        for (int k = 0; k < 8; k++) begin
            blk_i      = LIM_W'({idx_reg, 3'(k)});
            p2_byte[k] = !bm_byte[k] && (blk_i < lim_reg);
            p1_byte[k] = p2_byte[k] && (blk_i[0] == wb_reg[BLOCK_SHIFT]) &&
                         (blk_i != LIM_W'(lim_reg - 1'b1));
        end
        man_free                      = '0;
        man_free[MANIFEST_BLOCKS-1:0] = ~mbm_reg;
        man_byte    = man_free[{idx_reg[MAN_BYTE_W-1:0], 3'b000} +: 8];
        man_cnt_raw = '0;
        for (int j = 0; j < MANIFEST_BLOCKS; j++) begin
            man_cnt_raw = man_cnt_raw + 5'(man_free[j]);
        end
        man_cnt  = (SUM_W'(man_cnt_raw) > SUM_W'(MAX_PICKS)) ? CNT_W'(MAX_PICKS)
                                                              : CNT_W'(man_cnt_raw);
        sel_byte = cmd.msel_step ? man_byte : (pass2_reg ? p2_byte : p1_byte);
        sel_pop  = popcount8(sel_byte);
        acc_sum  = SUM_W'(acc_reg) + SUM_W'(sel_pop);
        sel_j    = 3'(mod_rem - acc_reg);
        sel_pos  = nth_set8(sel_byte, sel_j);
        body_sel = LIM_W'({idx_reg, sel_pos});
        body_sel_sum = {1'b0, wb_reg} + ((OFFSET_W + 1)'(body_sel) << BLOCK_SHIFT);
        n1_sum   = SUM_W'(n1_reg) + SUM_W'(popcount8(p1_byte));
        n2_sum   = SUM_W'(n2_reg) + SUM_W'(popcount8(p2_byte));
    end

    // Next-state of all datapath registers
    always_comb begin
        snd_next   = snd_reg;
        blen_next  = blen_reg;
        bm_next    = bm_reg;
        mbm_next   = mbm_reg;
        wb_next    = wb_reg;
        trk_next   = trk_reg;
        bsp_next   = bsp_reg;
        msp_next   = msp_reg;
        upd_next   = upd_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        lim_next   = lim_reg;
        pass2_next = pass2_reg;
        mod_start  = 1'b0;
        mod_div    = n1_reg;

        // Configuration writes
        if (cfg_wr) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SENDING_BUNDLE: snd_next  = cfg_data[TRK_W-1:0];
                CFG_BODY_LENGTH:    blen_next = cfg_data[OFFSET_W-1:0];
            endcase
        end

        if (cmd.load) begin
            upd_next = 1'b0;
        end

        // Apply the request
        if (cmd.exec) begin
            case (op_reg)
                OP_OBSERVE: begin
                    if (man_reg) begin
                        if (man_ok) mbm_next = mbm_reg | man_mask;
                    end else begin
                        if (is_reset) begin
                            mbm_next = '0;
                            trk_next = trk_eff;
                            wb_next  = wb_eff;
                        end
                        bm_next = (is_reset ? '0 : bm_reg) | (mark_ok ? mark_mask : '0);
                    end
                end
                OP_MOVE: begin
                    bm_next = moved;
                    wb_next = nb_reg;
                end
                OP_UPDATE: begin
                    if (sts.update_go) begin
                        upd_next = 1'b1;
                        lim_next = limit;
                        idx_next = '0;
                        acc_next = '0;
                        n1_next  = '0;
                        n2_next  = '0;
                    end
                end
                default: upd_next = 1'b0;
            endcase
        end

        // Count candidates of both passes, capped at the pick limit
        if (cmd.count_step) begin
            n1_next  = (n1_sum > SUM_W'(MAX_PICKS)) ? CNT_W'(MAX_PICKS) : n1_sum[CNT_W-1:0];
            n2_next  = (n2_sum > SUM_W'(MAX_PICKS)) ? CNT_W'(MAX_PICKS) : n2_sum[CNT_W-1:0];
            idx_next = idx_reg + 1'b1;
        end

        // Choose the body pass or fall back to the window end
        if (cmd.body_pick) begin
            idx_next   = '0;
            acc_next   = '0;
            pass2_next = (n1_reg == '0);
            if (sts.body_none) begin
                if (bsp_reg <= win_end) bsp_next = win_end;
            end else begin
                mod_start = 1'b1;
                mod_div   = (n1_reg != '0) ? n1_reg : n2_reg;
            end
        end

        // Find the chosen body candidate
        if (cmd.bsel_step) begin
            if (sts.sel_found) begin
                bsp_next = body_sel_sum[OFFSET_W] ? OFFSET_MAX : body_sel_sum[OFFSET_W-1:0];
            end else begin
                acc_next = acc_sum[CNT_W-1:0];
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.man_pick) begin
            idx_next = '0;
            acc_next = '0;
            if (sts.man_none) begin
                msp_next = MAN_FULL_POINT;
            end else begin
                mod_start = 1'b1;
                mod_div   = man_cnt;
            end
        end

        // Find the chosen manifest candidate
        if (cmd.msel_step) begin
            if (sts.sel_found) begin
                msp_next = MSO_W'({idx_reg[MAN_BYTE_W-1:0], sel_pos}) << BLOCK_SHIFT;
            end else begin
                acc_next = acc_sum[CNT_W-1:0];
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // Status to the controller
    always_comb begin
        sts.update_go = (op_reg == OP_UPDATE) && (trk_reg == snd_reg);
        sts.body_last = (idx_reg == BYW'(NBYTES - 1));
        sts.body_none = (n1_reg == '0) && (n2_reg == '0);
        sts.man_none  = (man_cnt == '0);
        sts.sel_found = (acc_sum > SUM_W'(mod_rem));
        sts.mod_done  = mod_done;
        sts.mod_busy  = mod_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snd_reg   <= NO_BUNDLE;
            blen_reg  <= '0;
            bm_reg    <= '0;
            mbm_reg   <= '0;
            wb_reg    <= '0;
            trk_reg   <= NO_BUNDLE;
            bsp_reg   <= '0;
            msp_reg   <= '0;
            upd_reg   <= 1'b0;
            idx_reg   <= '0;
            acc_reg   <= '0;
            n1_reg    <= '0;
            n2_reg    <= '0;
            lim_reg   <= '0;
            pass2_reg <= 1'b0;
        end else begin
            snd_reg   <= snd_next;
            blen_reg  <= blen_next;
            bm_reg    <= bm_next;
            mbm_reg   <= mbm_next;
            wb_reg    <= wb_next;
            trk_reg   <= trk_next;
            bsp_reg   <= bsp_next;
            msp_reg   <= msp_next;
            upd_reg   <= upd_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            lim_reg   <= lim_next;
            pass2_reg <= pass2_next;
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_tuser[1:0];
            man_reg   <= s_tuser[2];
            bid_reg   <= s_tdata[7:0];
            off_reg   <= s_tdata[31:8];
            bytes_reg <= s_tdata[43:32];
            pbl_reg   <= s_tdata[67:44];
            nb_reg    <= s_tdata[91:68];
            rnd_reg   <= s_tdata[107:92];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_bsp_reg <= bsp_reg;
            out_msp_reg <= msp_reg;
            out_upd_reg <= upd_reg;
        end
    end

    assign m_tdata = {(M_TDATA_W - OFFSET_W - MSO_W)'(0), out_msp_reg, out_bsp_reg};
    assign m_tuser = out_upd_reg;

endmodule

@@ design/piece_progress_bitmap_tracker.sv @@
// ----------------------------------------------------------------------------
// piece_progress_bitmap_tracker
// Tracks which blocks of a transfer a peer holds and picks send points.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (op and manifest flag in s_tuser, piece
//   and window fields in s_tdata); each request yields exactly one result
//   on the m_ stream with both send points and an updated flag in m_tuser.
//   The cfg_ channel writes sending_bundle (index 0) and body_length
//   (index 1); write it only while no request is in flight.
//   Observe, move, unused ops and an update on a bundle mismatch pass
//   through the dispatch and done states before m_tvalid rises. A
//   send-point update scans the body bitmap one byte per cycle, then runs
//   the shared remainder unit for the body and for the manifest, each run
//   followed by a scan until the picked block is found.
//   One request is worked at a time; s_tready rises together with m_tvalid,
//   so a new request is taken while that result waits.
//   Reset (synchronous, active-low aresetn) clears both bitmaps, the window
//   base and send points, marks no bundle tracked and sets sending_bundle
//   to none. A stalled m_tready holds the result and stops the next request
//   at its final step.
// ----------------------------------------------------------------------------
`include "piece_progress_bitmap_tracker_macros.svh"

module piece_progress_bitmap_tracker #(
    parameter int BODY_BLOCKS = ppbt_pkg::BODY_BLOCKS_DEF,
    parameter int MAX_PICKS   = ppbt_pkg::MAX_PICKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // bundle_id[7:0], piece_offset[31:8], piece_bytes[43:32],
    // piece_bundle_length[67:44], new_base[91:68], random_value[107:92]
    input  logic [ppbt_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[1:0], manifest_piece[2]
    input  logic [ppbt_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // body_send_offset[23:0], manifest_send_offset[34:24]
    output logic [ppbt_pkg::M_TDATA_W-1:0]   m_tdata,
    // send_point_updated[0]
    output logic [ppbt_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [ppbt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ppbt_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    assign cfg_ready = 1'b1;

    ppbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ppbt_datapath #(
        .BODY_BLOCKS(BODY_BLOCKS),
        .MAX_PICKS  (MAX_PICKS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks on controller sequencing
    `PPBT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `PPBT_ASSERT_IMPL(a_mod_not_idle, sts.mod_busy, !s_tready)
    `PPBT_ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, !m_tvalid || m_tready)

endmodule
